FILE: rtl/bpc_pkg.sv
package bpc_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned IDX_W  = 2;

   localparam logic [KIND_W-1:0] KIND_SHORT        = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LONG_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LONG_HOLD    = 2'd2;

   localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
   localparam logic [IDX_W-1:0] REG_SHORT_MIN    = 2'd1;
   localparam logic [IDX_W-1:0] REG_GRACE        = 2'd2;
   localparam logic [IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd3;

   localparam logic [LEN_W-1:0] DEBOUNCE_RST  = 16'd30;
   localparam logic [LEN_W-1:0] SHORT_MIN_RST = 16'd50;
   localparam logic [LEN_W-1:0] GRACE_RST     = 16'd1500;
   localparam logic [LEN_W-1:0] LEN_SAT       = 16'hFFFF;

   typedef struct packed {
      logic [LEN_W-1:0] debounce_ms;
      logic [LEN_W-1:0] short_min_ms;
      logic [LEN_W-1:0] grace_ms;
      logic             active_level;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] last_edge_ms;
      logic              press_active;
      logic [TIME_W-1:0] press_start_ms;
      logic              long_sent;
      logic [LEN_W-1:0]  last_press_len;
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              edge_pending;
      logic              edge_level;
      logic [TIME_W-1:0] edge_time_ms;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] event_kind;
      logic [TIME_W-1:0] event_time_ms;
      logic [LEN_W-1:0]  press_length_ms;
      logic [LEN_W-1:0]  last_press_ms;
   } result_type;

   function automatic logic [LEN_W-1:0] sat_len(input logic [TIME_W-1:0] v);
      logic [LEN_W-1:0] r;
      r = (|v[TIME_W-1:LEN_W]) ? LEN_SAT : v[LEN_W-1:0];
      return r;
   endfunction

endpackage

FILE: rtl/bpc_step.sv
module bpc_step (
   input  bpc_pkg::cfg_type    cfg,
   input  bpc_pkg::state_type  cur,
   input  bpc_pkg::item_type   item,
   output bpc_pkg::state_type  nxt,
   output bpc_pkg::result_type res
);
   import bpc_pkg::*;

   logic [TIME_W-1:0] edge_gap;
   logic [TIME_W-1:0] press_dur;
   logic [LEN_W-1:0]  press_len;
   logic [TIME_W-1:0] held;
   logic              edge_ok;
   state_type         mid;
   result_type        rel;

   assign edge_gap  = item.edge_time_ms - cur.last_edge_ms;
   assign edge_ok   = item.edge_pending && (edge_gap >= {{(TIME_W-LEN_W){1'b0}}, cfg.debounce_ms});
   assign press_dur = item.edge_time_ms - cur.press_start_ms;
   assign press_len = sat_len(press_dur);

   // edge handling first; a release clears the press before the hold check
   always_comb begin
      mid = cur;
      rel = '0;
      rel.event_time_ms   = item.edge_time_ms;
      rel.press_length_ms = press_len;
      if (edge_ok) begin
         mid.last_edge_ms = item.edge_time_ms;
         if (item.edge_level == cfg.active_level) begin
            mid.press_active   = 1'b1;
            mid.press_start_ms = item.edge_time_ms;
            mid.long_sent      = 1'b0;
         end else begin
            if (cur.press_active) begin
               mid.last_press_len = press_len;
               if (!cur.long_sent) begin
                  if (press_len >= cfg.grace_ms) begin
                     rel.valid      = 1'b1;
                     rel.event_kind = KIND_LONG_RELEASE;
                  end else if (press_len >= cfg.short_min_ms) begin
                     rel.valid      = 1'b1;
                     rel.event_kind = KIND_SHORT;
                  end
               end
            end
            mid.press_active   = 1'b0;
            mid.press_start_ms = '0;
            mid.long_sent      = 1'b0;
         end
      end
   end

   assign held = item.now_ms - mid.press_start_ms;

   always_comb begin
      nxt = mid;
      res = rel;
      if (mid.press_active && !mid.long_sent
          && held >= {{(TIME_W-LEN_W){1'b0}}, cfg.grace_ms}) begin
         nxt.long_sent       = 1'b1;
         res.valid           = 1'b1;
         res.event_kind      = KIND_LONG_HOLD;
         res.event_time_ms   = item.now_ms;
         res.press_length_ms = sat_len(held);
      end
      res.last_press_ms = mid.last_press_len;
   end

endmodule

FILE: rtl/button_press_classifier.sv
// channel | dir | handshake              | payload
// req     | in  | req_valid / req_stall  | now_ms, edge_pending, edge_level, edge_time_ms
// rsp     | out | rsp_valid / rsp_stall  | event_kind, event_time_ms, press_length_ms,
//         |     |                        | last_press_ms
// csr     | in  | csr_valid / csr_ready  | csr_index, csr_data
//
// One poll per cycle while the result is not stalled. A poll is held in the input register, then the press
// state and the result register update together; zero or one event per poll.
// rsp_valid rises when an evaluated poll with an event loads the result register.
// Synchronous reset loads the default thresholds and clears all press state.
// A stalled result holds the evaluation; the input register still takes one poll.
module button_press_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bpc_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                           req_edge_pending,
   input  logic                           req_edge_level,
   input  logic [bpc_pkg::TIME_W-1:0]     req_edge_time_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bpc_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic [bpc_pkg::TIME_W-1:0]     rsp_event_time_ms,
   output logic [bpc_pkg::LEN_W-1:0]      rsp_press_length_ms,
   output logic [bpc_pkg::LEN_W-1:0]      rsp_last_press_ms,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bpc_pkg::IDX_W-1:0]      csr_index,
   input  logic [bpc_pkg::LEN_W-1:0]      csr_data
);
   import bpc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  st_ff, st_nxt;
   item_type   item_ff;
   result_type res;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] kind_ff;
   logic [TIME_W-1:0] etime_ff;
   logic [LEN_W-1:0]  plen_ff;
   logic [LEN_W-1:0]  lastp_ff;
   logic       req_xfer;
   logic       process;

   assign process   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !process;
   assign req_xfer  = req_valid && !req_stall;
   // thresholds move only with no poll and no event in flight
   assign csr_ready = !in_valid_ff && !out_valid_ff;

   bpc_step u_step (
      .cfg  (cfg_ff),
      .cur  (st_ff),
      .item (item_ff),
      .nxt  (st_nxt),
      .res  (res)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DEBOUNCE:     cfg_in.debounce_ms  = csr_data;
            REG_SHORT_MIN:    cfg_in.short_min_ms = csr_data;
            REG_GRACE:        cfg_in.grace_ms     = csr_data;
            REG_ACTIVE_LEVEL: cfg_in.active_level = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (process) begin
         out_valid_in = res.valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= DEBOUNCE_RST;
         cfg_ff.short_min_ms <= SHORT_MIN_RST;
         cfg_ff.grace_ms     <= GRACE_RST;
         cfg_ff.active_level <= 1'b0;
         st_ff               <= '0;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            st_ff <= st_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.now_ms       <= req_now_ms;
         item_ff.edge_pending <= req_edge_pending;
         item_ff.edge_level   <= req_edge_level;
         item_ff.edge_time_ms <= req_edge_time_ms;
      end
      if (process && res.valid) begin
         kind_ff  <= res.event_kind;
         etime_ff <= res.event_time_ms;
         plen_ff  <= res.press_length_ms;
         lastp_ff <= res.last_press_ms;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_event_kind      = kind_ff;
   assign rsp_event_time_ms   = etime_ff;
   assign rsp_press_length_ms = plen_ff;
   assign rsp_last_press_ms   = lastp_ff;

`ifndef SYNTHESIS
   // an idle press carries no start time and no pending long flag
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !st_ff.press_active |-> (st_ff.press_start_ms == '0) && !st_ff.long_sent)
      else $error("idle press state not cleared");

   // a hold event marks the press as reported
   a_hold_marks: assert property (@(posedge clock) disable iff (reset)
      process && res.valid && (res.event_kind == KIND_LONG_HOLD) |=> st_ff.long_sent)
      else $error("hold event did not set long flag");

   // a short event always lies below the long threshold
   a_short_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == KIND_SHORT)
      |-> (rsp_press_length_ms < cfg_ff.grace_ms)
          && (rsp_press_length_ms >= cfg_ff.short_min_ms))
      else $error("short event outside short range");

   // state only moves when a poll is evaluated
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !process |=> $stable(st_ff))
      else $error("press state changed without a poll");
`endif

endmodule

FILE: tb/button_press_classifier_tb.sv
module button_press_classifier_tb;
   import bpc_pkg::*;

   localparam int NUM_PHASES   = 6;
   localparam int PHASE_POLLS  = 140;
   localparam int HOLD_OFF     = 4;
   localparam int TAIL_CYCLES  = 8;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SHOW_LIMIT   = 10;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] stamp_ms;
      logic [LEN_W-1:0]  len_ms;
      logic [LEN_W-1:0]  last_len_ms;
   } press_event_type;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_EVENT} check_mode_type;
   typedef enum logic {ROW_POLL, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type     op;
      logic [IDX_W-1:0] reg_index;
      logic [LEN_W-1:0] reg_data;
      item_type         poll;
      check_mode_type   chk;
      press_event_type  ev;
   } script_row_type;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [TIME_W-1:0]   req_now_ms       = '0;
   logic                req_edge_pending = 1'b0;
   logic                req_edge_level   = 1'b0;
   logic [TIME_W-1:0]   req_edge_time_ms = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [KIND_W-1:0]   rsp_event_kind;
   logic [TIME_W-1:0]   rsp_event_time_ms;
   logic [LEN_W-1:0]    rsp_press_length_ms;
   logic [LEN_W-1:0]    rsp_last_press_ms;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index        = '0;
   logic [LEN_W-1:0]    csr_data         = '0;

   button_press_classifier dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_now_ms          (req_now_ms),
      .req_edge_pending    (req_edge_pending),
      .req_edge_level      (req_edge_level),
      .req_edge_time_ms    (req_edge_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_event_time_ms   (rsp_event_time_ms),
      .rsp_press_length_ms (rsp_press_length_ms),
      .rsp_last_press_ms   (rsp_last_press_ms),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // classifier mirror: thresholds and press tracking
   cfg_type           cfg_now = '{DEBOUNCE_RST, SHORT_MIN_RST, GRACE_RST, 1'b0};
   logic [TIME_W-1:0] last_edge_ms  = '0;
   logic              pressed       = 1'b0;
   logic [TIME_W-1:0] press_start   = '0;
   logic              long_sent     = 1'b0;
   logic [LEN_W-1:0]  last_len      = '0;

   press_event_type   due_events[$];
   script_row_type    script[$];

   bit                calm = 1'b0;
   logic [TIME_W-1:0] ms_clock       = '0;
   logic [TIME_W-1:0] last_edge_sent = '0;
   logic              pin_level      = 1'b0;

   int polls_sent   = 0;
   int events_seen  = 0;
   int csr_writes   = 0;
   int mismatches   = 0;
   int quiet_cycles = 0;
   int kind_seen[3] = '{0, 0, 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [LEN_W-1:0] clip_len(input logic [TIME_W-1:0] span);
      return (span > 32'h0000_FFFF) ? LEN_SAT : span[LEN_W-1:0];
   endfunction

   task automatic classify_poll(input item_type p, output bit fired,
                                output press_event_type ev);
      logic [TIME_W-1:0] span;
      fired = 1'b0;
      ev = '0;
      span = p.edge_time_ms - last_edge_ms;
      if (p.edge_pending && span >= cfg_now.debounce_ms) begin
         last_edge_ms = p.edge_time_ms;
         if (p.edge_level == cfg_now.active_level) begin
            pressed = 1'b1;
            press_start = p.edge_time_ms;
            long_sent = 1'b0;
         end else begin
            if (pressed) begin
               last_len = clip_len(p.edge_time_ms - press_start);
               if (!long_sent) begin
                  if (last_len >= cfg_now.grace_ms) begin
                     fired = 1'b1;
                     ev.kind = KIND_LONG_RELEASE;
                  end else if (last_len >= cfg_now.short_min_ms) begin
                     fired = 1'b1;
                     ev.kind = KIND_SHORT;
                  end
                  ev.stamp_ms = p.edge_time_ms;
                  ev.len_ms = last_len;
               end
            end
            pressed = 1'b0;
            press_start = '0;
            long_sent = 1'b0;
         end
      end
      // release is handled first, so a poll never gives two events
      if (pressed && !long_sent) begin
         span = p.now_ms - press_start;
         if (span >= cfg_now.grace_ms) begin
            fired = 1'b1;
            long_sent = 1'b1;
            ev.kind = KIND_LONG_HOLD;
            ev.stamp_ms = p.now_ms;
            ev.len_ms = clip_len(span);
         end
      end
      ev.last_len_ms = last_len;
   endtask

   task automatic send_poll(input item_type p, input check_mode_type chk,
                            input press_event_type fixed);
      bit              fired;
      press_event_type ev;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= p.now_ms;
      req_edge_pending <= p.edge_pending;
      req_edge_level <= p.edge_level;
      req_edge_time_ms <= p.edge_time_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_poll(p, fired, ev);
      case (chk)
         CHK_MODEL: if (fired) due_events.push_back(ev);
         CHK_EVENT: due_events.push_back(fixed);
         default: ;
      endcase
      polls_sent++;
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_DEBOUNCE:     cfg_now.debounce_ms = data;
         REG_SHORT_MIN:    cfg_now.short_min_ms = data;
         REG_GRACE:        cfg_now.grace_ms = data;
         REG_ACTIVE_LEVEL: cfg_now.active_level = data[0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop polling, wait until every predicted event is out, then idle for the extra clocks given
   task automatic drain_pipe(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_events.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic add_poll(input check_mode_type chk, input logic [TIME_W-1:0] now,
                           input logic pend, input logic lvl, input logic [TIME_W-1:0] etime);
      script_row_type row;
      row = '{op: ROW_POLL, reg_index: '0, reg_data: '0,
              poll: '{now, pend, lvl, etime}, chk: chk, ev: '0};
      script.push_back(row);
   endtask

   task automatic add_event(input logic [TIME_W-1:0] now, input logic pend, input logic lvl,
                            input logic [TIME_W-1:0] etime, input logic [KIND_W-1:0] kind,
                            input logic [TIME_W-1:0] stamp, input logic [LEN_W-1:0] len,
                            input logic [LEN_W-1:0] last);
      script_row_type row;
      row = '{op: ROW_POLL, reg_index: '0, reg_data: '0,
              poll: '{now, pend, lvl, etime}, chk: CHK_EVENT,
              ev: '{kind, stamp, len, last}};
      script.push_back(row);
   endtask

   task automatic add_cfg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
      script_row_type row;
      row = '{op: ROW_CFG, reg_index: idx, reg_data: data,
              poll: '0, chk: CHK_NONE, ev: '0};
      script.push_back(row);
   endtask

   task automatic random_poll(input int unsigned scale);
      item_type    p;
      int unsigned roll;
      int unsigned delta;
      roll = $urandom_range(0, 99);
      delta = $urandom_range(0, scale);
      if ($urandom_range(0, 7) == 0)
         delta = $urandom_range(0, 8);
      p.now_ms = ms_clock + delta;
      p.edge_pending = 1'b0;
      p.edge_level = 1'($urandom_range(0, 1));
      p.edge_time_ms = $urandom;
      if (roll < 60) begin
         // clean alternating press / release
         pin_level = ~pin_level;
         p.edge_pending = 1'b1;
         p.edge_level = pin_level;
         p.edge_time_ms = ms_clock + $urandom_range(0, delta);
         last_edge_sent = p.edge_time_ms;
      end else if (roll < 70) begin
         // contact bounce close behind the previous edge
         p.edge_pending = 1'b1;
         p.edge_time_ms = last_edge_sent + $urandom_range(0, cfg_now.debounce_ms);
      end else if (roll >= 88) begin
         p.edge_pending = 1'($urandom_range(0, 1));
      end
      ms_clock = p.now_ms;
      send_poll(p, CHK_MODEL, '0);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
   end

   always @(posedge clock) begin : check_events
      press_event_type got;
      press_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_event_kind, rsp_event_time_ms, rsp_press_length_ms, rsp_last_press_ms};
         events_seen++;
         if (got.kind <= KIND_LONG_HOLD)
            kind_seen[got.kind]++;
         if (due_events.size() == 0) begin
            if (mismatches < SHOW_LIMIT)
               $display("unexpected event: kind %0d time %0d len %0d last %0d",
                        got.kind, got.stamp_ms, got.len_ms, got.last_len_ms);
            mismatches++;
         end else begin
            want = due_events.pop_front();
            if (got.kind !== want.kind || got.stamp_ms !== want.stamp_ms ||
                got.len_ms !== want.len_ms || got.last_len_ms !== want.last_len_ms) begin
               if (mismatches < SHOW_LIMIT) begin
                  $display("event %0d: expected kind %0d time %0d len %0d last %0d",
                           events_seen, want.kind, want.stamp_ms, want.len_ms,
                           want.last_len_ms);
                  $display("event %0d: got      kind %0d time %0d len %0d last %0d",
                           events_seen, got.kind, got.stamp_ms, got.len_ms,
                           got.last_len_ms);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no transfer in %0d cycles, %0d events still due",
                  QUIET_LIMIT, due_events.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned      scale;
      logic [LEN_W-1:0] deb;
      logic [LEN_W-1:0] smin;
      logic [LEN_W-1:0] grc;
      logic             lvl;

      // directed: reset thresholds (debounce 30, short 50, grace 1500, active low)
      add_poll(CHK_NONE,  32'd0,    1'b0, 1'b0, 32'd0);
      add_poll(CHK_MODEL, 32'd100,  1'b1, 1'b1, 32'd100);    // release with no press
      add_poll(CHK_MODEL, 32'd200,  1'b1, 1'b0, 32'd200);
      add_poll(CHK_MODEL, 32'd210,  1'b1, 1'b1, 32'd210);    // bounce, dropped
      add_poll(CHK_MODEL, 32'd300,  1'b1, 1'b1, 32'd300);    // short press
      add_poll(CHK_MODEL, 32'd400,  1'b1, 1'b0, 32'd400);
      add_poll(CHK_MODEL, 32'd430,  1'b1, 1'b1, 32'd430);    // too short, length kept
      add_poll(CHK_MODEL, 32'd500,  1'b1, 1'b0, 32'd500);
      add_poll(CHK_MODEL, 32'd1000, 1'b1, 1'b0, 32'd1000);   // second press edge restarts
      add_poll(CHK_MODEL, 32'd2499, 1'b0, 1'b1, 32'hFFFF_FFFF);
      add_event(32'd2500, 1'b0, 1'b0, 32'd0, KIND_LONG_HOLD, 32'd2500, 16'd1500, 16'd30);
      add_poll(CHK_NONE,  32'd3000, 1'b1, 1'b1, 32'd3000);   // release after hold is silent
      add_poll(CHK_MODEL, 32'd4000, 1'b1, 1'b0, 32'd4000);
      add_event(32'd70000, 1'b1, 1'b1, 32'd70000, KIND_LONG_RELEASE, 32'd70000,
                LEN_SAT, LEN_SAT);
      add_poll(CHK_MODEL, 32'hFFFF_FF00, 1'b1, 1'b0, 32'hFFFF_FF00);
      add_event(32'h10, 1'b1, 1'b1, 32'h10, KIND_SHORT, 32'h10, 16'd272, 16'd272);
      add_poll(CHK_NONE,  32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
      add_cfg(REG_ACTIVE_LEVEL, 16'd1);
      add_cfg(REG_GRACE, 16'd0);
      add_cfg(REG_DEBOUNCE, LEN_SAT);
      add_cfg(REG_SHORT_MIN, LEN_SAT);
      add_event(32'h1_0010, 1'b1, 1'b1, 32'h1_0010, KIND_LONG_HOLD, 32'h1_0010,
                16'd0, 16'd272);
      add_poll(CHK_MODEL, 32'h1_0020, 1'b1, 1'b0, 32'h1_0020);
      add_cfg(REG_DEBOUNCE, 16'd0);
      add_cfg(REG_GRACE, 16'd100);
      add_cfg(REG_SHORT_MIN, 16'd200);
      add_poll(CHK_MODEL, 32'h1_0030, 1'b1, 1'b0, 32'h1_0030);
      add_poll(CHK_MODEL, 32'h2_0000, 1'b1, 1'b1, 32'h2_0000);
      add_event(32'h2_0096, 1'b1, 1'b0, 32'h2_0096, KIND_LONG_RELEASE, 32'h2_0096,
                16'd150, 16'd150);
      add_poll(CHK_MODEL, 32'h3_0000, 1'b1, 1'b1, 32'h3_0000);
      add_poll(CHK_MODEL, 32'h3_0032, 1'b1, 1'b0, 32'h3_0032);  // no short range left

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].op == ROW_CFG) begin
            drain_pipe(HOLD_OFF);
            write_reg(script[i].reg_index, script[i].reg_data);
         end else begin
            send_poll(script[i].poll, script[i].chk, script[i].ev);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin
               deb = DEBOUNCE_RST;
               smin = SHORT_MIN_RST;
               grc = GRACE_RST;
               lvl = 1'b0;
            end
            1: begin
               deb = '0;
               smin = '0;
               grc = LEN_SAT;
               lvl = 1'b1;
            end
            2: begin
               deb = LEN_W'($urandom_range(0, 40));
               smin = LEN_W'($urandom_range(0, 300));
               grc = smin + LEN_W'($urandom_range(1, 1500));
               lvl = 1'($urandom_range(0, 1));
            end
            3: begin
               grc = LEN_W'($urandom_range(0, 800));
               smin = grc + LEN_W'($urandom_range(0, 500));
               deb = LEN_SAT;
               lvl = 1'b0;
            end
            4: begin
               deb = LEN_W'($urandom_range(0, 10));
               smin = '0;
               grc = '0;
               lvl = 1'($urandom_range(0, 1));
            end
            default: begin
               deb = LEN_W'($urandom_range(0, 65535));
               smin = LEN_W'($urandom_range(0, 65535));
               grc = LEN_W'($urandom_range(0, 65535));
               lvl = 1'($urandom_range(0, 1));
            end
         endcase
         drain_pipe(HOLD_OFF);
         write_reg(REG_DEBOUNCE, deb);
         write_reg(REG_SHORT_MIN, smin);
         write_reg(REG_GRACE, grc);
         write_reg(REG_ACTIVE_LEVEL, {{(LEN_W-1){1'b0}}, lvl});
         calm = (ph == 2);
         // phase 1 starts just below the top so the time base wraps early on
         ms_clock = (ph == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 300000) : $urandom;
         last_edge_sent = ms_clock;
         scale = cfg_now.grace_ms + cfg_now.grace_ms / 2 + cfg_now.debounce_ms + 8;
         repeat (PHASE_POLLS) random_poll(scale);
      end

      calm = 1'b0;
      drain_pipe(TAIL_CYCLES);

      $display("%0d polls, %0d register writes, %0d threshold phases, %0d events checked",
               polls_sent, csr_writes, NUM_PHASES + 3, events_seen);
      $display("short %0d, long at release %0d, long on hold %0d, mismatches %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
